[rtl/rrli_pkg.sv]
// rrli_pkg: widths, register indexes and the beat type shared by the
// rectangle light intersection pipeline and its divider
// depends on nothing
package rrli_pkg;

    // coordinate format, signed q8.8
    localparam int CW       = 16;
    localparam int T_FRAC   = 16;
    localparam int REG_W    = 3 * CW;
    localparam int RGB_W    = 48;

    // front end widths
    localparam int AW       = CW + 1;
    localparam int PN_W     = 2 * CW + 1;
    localparam int PD_W     = 2 * CW;
    localparam int NUM_W    = 2 * CW + 3;
    localparam int DEN_W    = 2 * CW + 2;
    localparam int NMAG_W   = 2 * CW + 1;
    localparam int DMAG_W   = 2 * CW;

    // divider widths
    localparam int NDIV     = 4;
    localparam int Q_W      = 32;
    localparam int DVD_W    = NMAG_W + T_FRAC;
    localparam int CMP_W    = DMAG_W + Q_W;

    // back end widths
    localparam int QC       = CW + 4;
    localparam int QS_W     = CW + 6;
    localparam int P_W      = CW + 7;
    localparam int D_W      = CW + 4;
    localparam int DE_W     = 2 * CW + 6;
    localparam int EE_W     = 2 * CW + 2;
    localparam int DLIM     = 1 << (CW + 2);
    localparam int SMAX     = (1 << (CW - 1)) - 1;
    localparam int SMIN     = -(1 << (CW - 1));

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_U = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_V = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RGB    = 3'd5;

    // what travels beside the quotients through the divider
    typedef struct packed {
        logic                  miss;
        logic [2:0][CW-1:0]    o;
        logic [2:0]            rneg;
    } side_t;

endpackage

[rtl/ray_rectangle_light_intersect_top.sv]
// ray_rectangle_light_intersect_top: ray against rectangular area light,
// configuration registers, front and back arithmetic stages, output skid
// depends on rrli_pkg and rrli_div

// Takes one ray per clock and returns one result per ray, in order. A ray
// passes five front stages of offsets, products, sums, magnitudes and
// dividends, then the divider, 33 stages in all, whose first stage flags
// quotients that do not fit and whose others each resolve one quotient bit
// of t and of the three hit point offsets, then three back stages of hit
// point, clamps and edge dot products ahead of the edge tests. An output
// register with a one-beat skid lets the pipeline run while a result
// waits; ray_ready falls only when the skid is full. Configuration writes
// are taken at any time but must be made while no ray is in flight.
module ray_rectangle_light_intersect_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rrli_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rrli_pkg::REG_W-1:0]            cfg_data,
    // rays
    input  logic                                  ray_valid,
    output logic                                  ray_ready,
    input  logic signed [rrli_pkg::CW-1:0]        origin_x,
    input  logic signed [rrli_pkg::CW-1:0]        origin_y,
    input  logic signed [rrli_pkg::CW-1:0]        origin_z,
    input  logic signed [rrli_pkg::CW-1:0]        dir_x,
    input  logic signed [rrli_pkg::CW-1:0]        dir_y,
    input  logic signed [rrli_pkg::CW-1:0]        dir_z,
    // results
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic                                  hit,
    output logic [rrli_pkg::Q_W-1:0]              distance_t,
    output logic signed [rrli_pkg::CW-1:0]        hit_x,
    output logic signed [rrli_pkg::CW-1:0]        hit_y,
    output logic signed [rrli_pkg::CW-1:0]        hit_z,
    output logic [rrli_pkg::RGB_W-1:0]            emitted_rgb
);

    typedef struct packed {
        logic                                hit;
        logic [rrli_pkg::Q_W-1:0]            t;
        logic [2:0][rrli_pkg::CW-1:0]        p;
        logic [rrli_pkg::RGB_W-1:0]          rgb;
    } res_t;

    // configuration registers
    logic                                    area_reg;
    logic [rrli_pkg::REG_W-1:0]              center_reg;
    logic [rrli_pkg::REG_W-1:0]              normal_reg;
    logic [rrli_pkg::REG_W-1:0]              edge_u_reg;
    logic [rrli_pkg::REG_W-1:0]              edge_v_reg;
    logic [rrli_pkg::RGB_W-1:0]              rgb_reg;

    logic signed [rrli_pkg::CW-1:0]          cen_s [3];
    logic signed [rrli_pkg::CW-1:0]          nrm_s [3];
    logic signed [rrli_pkg::CW-1:0]          eu_s  [3];
    logic signed [rrli_pkg::CW-1:0]          ev_s  [3];
    logic signed [rrli_pkg::CW-1:0]          in_o  [3];
    logic signed [rrli_pkg::CW-1:0]          in_r  [3];

    logic                                    en;
    logic [4:0]                              fv_reg;
    logic [2:0]                              bv_reg;

    // front stages
    logic signed [rrli_pkg::CW-1:0]          s1_o   [3];
    logic signed [rrli_pkg::CW-1:0]          s1_r   [3];
    logic signed [rrli_pkg::AW-1:0]          s1_a   [3];
    logic signed [rrli_pkg::CW-1:0]          s2_o   [3];
    logic signed [rrli_pkg::CW-1:0]          s2_r   [3];
    logic signed [rrli_pkg::PN_W-1:0]        s2_pn  [3];
    logic signed [rrli_pkg::PD_W-1:0]        s2_pd  [3];
    logic signed [rrli_pkg::CW-1:0]          s3_o   [3];
    logic signed [rrli_pkg::CW-1:0]          s3_r   [3];
    logic signed [rrli_pkg::NUM_W-1:0]       s3_num;
    logic signed [rrli_pkg::DEN_W-1:0]       s3_den;
    logic [2:0][rrli_pkg::CW-1:0]            s4_o;
    logic [rrli_pkg::CW-1:0]                 s4_rmag [3];
    logic [2:0]                              s4_rneg;
    logic [rrli_pkg::NMAG_W-1:0]             s4_nmag;
    logic [rrli_pkg::DMAG_W-1:0]             s4_dmag;
    logic                                    s4_miss;
    logic [rrli_pkg::NDIV-1:0][rrli_pkg::DVD_W-1:0] s5_dvd;
    logic [rrli_pkg::DMAG_W-1:0]             s5_dsr;
    rrli_pkg::side_t                         s5_side;

    // divider outputs
    logic                                    div_valid;
    logic [rrli_pkg::NDIV-1:0][rrli_pkg::Q_W-1:0] div_quo;
    logic [rrli_pkg::NDIV-1:0]               div_ovf;
    rrli_pkg::side_t                         div_side;

    // back stages
    logic signed [rrli_pkg::P_W-1:0]         p_next [3];
    logic [rrli_pkg::Q_W-1:0]                s6_t;
    logic signed [rrli_pkg::P_W-1:0]         s6_p   [3];
    logic                                    s6_miss;
    logic [rrli_pkg::Q_W-1:0]                s7_t;
    logic signed [rrli_pkg::D_W-1:0]         s7_d   [3];
    logic [2:0][rrli_pkg::CW-1:0]            s7_pc;
    logic                                    s7_miss;
    logic signed [rrli_pkg::P_W:0]           dif_next [3];
    logic [rrli_pkg::Q_W-1:0]                s8_t;
    logic [2:0][rrli_pkg::CW-1:0]            s8_pc;
    logic                                    s8_miss;
    logic signed [rrli_pkg::DE_W-1:0]        s8_deu;
    logic signed [rrli_pkg::DE_W-1:0]        s8_dev;
    logic signed [rrli_pkg::EE_W-1:0]        s8_eeu;
    logic signed [rrli_pkg::EE_W-1:0]        s8_eev;

    // result and output
    res_t                                    res_next;
    res_t                                    out_res_reg;
    res_t                                    skid_res_reg;
    logic                                    out_valid_reg;
    logic                                    skid_valid_reg;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_reg   <= 1'b0;
            center_reg <= '0;
            normal_reg <= '0;
            edge_u_reg <= '0;
            edge_v_reg <= '0;
            rgb_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rrli_pkg::CFG_AREA:   area_reg   <= cfg_data[0];
                rrli_pkg::CFG_CENTER: center_reg <= cfg_data;
                rrli_pkg::CFG_NORMAL: normal_reg <= cfg_data;
                rrli_pkg::CFG_EDGE_U: edge_u_reg <= cfg_data;
                rrli_pkg::CFG_EDGE_V: edge_v_reg <= cfg_data;
                rrli_pkg::CFG_RGB:    rgb_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // unpack vectors, x in the low bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cen_s[i] = $signed(center_reg[i*rrli_pkg::CW +: rrli_pkg::CW]);
            nrm_s[i] = $signed(normal_reg[i*rrli_pkg::CW +: rrli_pkg::CW]);
            eu_s[i]  = $signed(edge_u_reg[i*rrli_pkg::CW +: rrli_pkg::CW]);
            ev_s[i]  = $signed(edge_v_reg[i*rrli_pkg::CW +: rrli_pkg::CW]);
        end
        in_o[0] = origin_x;
        in_o[1] = origin_y;
        in_o[2] = origin_z;
        in_r[0] = dir_x;
        in_r[1] = dir_y;
        in_r[2] = dir_z;
    end

    // whole pipeline moves unless the skid holds a beat
    assign en        = !skid_valid_reg;
    assign ray_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
            bv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[3:0], ray_valid};
            bv_reg <= {bv_reg[1:0], div_valid};
        end
    end

    // front: offsets, products, sums, magnitudes, dividends
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_o[i]  <= in_o[i];
                s1_r[i]  <= in_r[i];
                s1_a[i]  <= rrli_pkg::AW'(cen_s[i]) - rrli_pkg::AW'(in_o[i]);

                s2_o[i]  <= s1_o[i];
                s2_r[i]  <= s1_r[i];
                s2_pn[i] <= rrli_pkg::PN_W'(s1_a[i]) * rrli_pkg::PN_W'(nrm_s[i]);
                s2_pd[i] <= rrli_pkg::PD_W'(s1_r[i]) * rrli_pkg::PD_W'(nrm_s[i]);

                s3_o[i]  <= s2_o[i];
                s3_r[i]  <= s2_r[i];

                s4_o[i]    <= s3_o[i];
                s4_rneg[i] <= s3_r[i][rrli_pkg::CW-1];
                s4_rmag[i] <= rrli_pkg::CW'((s3_r[i] < 0) ? -s3_r[i] : s3_r[i]);

                s5_dvd[i+1] <= rrli_pkg::DVD_W'(s4_nmag) * rrli_pkg::DVD_W'(s4_rmag[i]);
            end
            s3_num <= rrli_pkg::NUM_W'(s2_pn[0]) + rrli_pkg::NUM_W'(s2_pn[1])
                      + rrli_pkg::NUM_W'(s2_pn[2]);
            s3_den <= rrli_pkg::DEN_W'(s2_pd[0]) + rrli_pkg::DEN_W'(s2_pd[1])
                      + rrli_pkg::DEN_W'(s2_pd[2]);

            s4_nmag <= rrli_pkg::NMAG_W'((s3_num < 0) ? -s3_num : s3_num);
            s4_dmag <= rrli_pkg::DMAG_W'((s3_den < 0) ? -s3_den : s3_den);
            s4_miss <= !area_reg || (s3_den == 0) || (s3_num == 0)
                       || (s3_num[rrli_pkg::NUM_W-1] != s3_den[rrli_pkg::DEN_W-1]);

            s5_dvd[0]    <= rrli_pkg::DVD_W'({s4_nmag, {rrli_pkg::T_FRAC{1'b0}}});
            s5_dsr       <= s4_dmag;
            s5_side.miss <= s4_miss;
            s5_side.o    <= s4_o;
            s5_side.rneg <= s4_rneg;
        end
    end

    rrli_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fv_reg[4]),
        .dividend  (s5_dvd),
        .divisor   (s5_dsr),
        .side_in   (s5_side),
        .out_valid (div_valid),
        .quotient  (div_quo),
        .overflow  (div_ovf),
        .side_out  (div_side)
    );

    // hit point from clipped signed offset
    always_comb
    begin
        logic [rrli_pkg::QC:0]            qmag;
        logic signed [rrli_pkg::QS_W-1:0] qs;
        qmag = '0;
        qs   = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (div_ovf[i+1] || (div_quo[i+1] >= rrli_pkg::Q_W'(1 << rrli_pkg::QC)))
            begin
                qmag = (rrli_pkg::QC+1)'(1 << rrli_pkg::QC);
            end
            else
            begin
                qmag = div_quo[i+1][rrli_pkg::QC:0];
            end
            qs = div_side.rneg[i] ? -rrli_pkg::QS_W'(qmag) : rrli_pkg::QS_W'(qmag);
            p_next[i] = rrli_pkg::P_W'($signed(div_side.o[i])) + rrli_pkg::P_W'(qs);
        end
    end

    // offset from centre
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dif_next[i] = (rrli_pkg::P_W+1)'(s6_p[i]) - (rrli_pkg::P_W+1)'(cen_s[i]);
        end
    end

    // back: hit point, clamps, edge dot products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_t    <= div_ovf[0] ? '1 : div_quo[0];
            s6_miss <= div_side.miss;
            s7_t    <= s6_t;
            s7_miss <= s6_miss;
            s8_t    <= s7_t;
            s8_miss <= s7_miss;
            s8_pc   <= s7_pc;
            for (int i = 0; i < 3; i++)
            begin
                s6_p[i] <= p_next[i];

                if (dif_next[i] > rrli_pkg::DLIM)
                    s7_d[i] <= rrli_pkg::D_W'(rrli_pkg::DLIM);
                else if (dif_next[i] < -rrli_pkg::DLIM)
                    s7_d[i] <= rrli_pkg::D_W'(-rrli_pkg::DLIM);
                else
                    s7_d[i] <= rrli_pkg::D_W'(dif_next[i]);

                if (s6_p[i] > rrli_pkg::SMAX)
                    s7_pc[i] <= rrli_pkg::CW'(rrli_pkg::SMAX);
                else if (s6_p[i] < rrli_pkg::SMIN)
                    s7_pc[i] <= rrli_pkg::CW'(rrli_pkg::SMIN);
                else
                    s7_pc[i] <= rrli_pkg::CW'(s6_p[i]);
            end
            s8_deu <= rrli_pkg::DE_W'(s7_d[0]) * rrli_pkg::DE_W'(eu_s[0])
                      + rrli_pkg::DE_W'(s7_d[1]) * rrli_pkg::DE_W'(eu_s[1])
                      + rrli_pkg::DE_W'(s7_d[2]) * rrli_pkg::DE_W'(eu_s[2]);
            s8_dev <= rrli_pkg::DE_W'(s7_d[0]) * rrli_pkg::DE_W'(ev_s[0])
                      + rrli_pkg::DE_W'(s7_d[1]) * rrli_pkg::DE_W'(ev_s[1])
                      + rrli_pkg::DE_W'(s7_d[2]) * rrli_pkg::DE_W'(ev_s[2]);
            s8_eeu <= rrli_pkg::EE_W'(eu_s[0]) * rrli_pkg::EE_W'(eu_s[0])
                      + rrli_pkg::EE_W'(eu_s[1]) * rrli_pkg::EE_W'(eu_s[1])
                      + rrli_pkg::EE_W'(eu_s[2]) * rrli_pkg::EE_W'(eu_s[2]);
            s8_eev <= rrli_pkg::EE_W'(ev_s[0]) * rrli_pkg::EE_W'(ev_s[0])
                      + rrli_pkg::EE_W'(ev_s[1]) * rrli_pkg::EE_W'(ev_s[1])
                      + rrli_pkg::EE_W'(ev_s[2]) * rrli_pkg::EE_W'(ev_s[2]);
        end
    end

    // edge tests and result selection
    always_comb
    begin
        logic signed [rrli_pkg::DE_W-1:0] abs_u;
        logic signed [rrli_pkg::DE_W-1:0] abs_v;
        logic                             in_u;
        logic                             in_v;
        abs_u = (s8_deu < 0) ? -s8_deu : s8_deu;
        abs_v = (s8_dev < 0) ? -s8_dev : s8_dev;
        in_u  = (s8_eeu != 0) && (abs_u <= rrli_pkg::DE_W'(s8_eeu));
        in_v  = (s8_eev != 0) && (abs_v <= rrli_pkg::DE_W'(s8_eev));
        res_next.hit = !s8_miss && in_u && in_v;
        res_next.t   = res_next.hit ? s8_t : '1;
        res_next.p   = res_next.hit ? s8_pc : '0;
        res_next.rgb = res_next.hit ? rgb_reg : '0;
    end

    // output register with one-beat skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !res_ready)
        begin
            if (bv_reg[2] && en)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= bv_reg[2] && en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !res_ready)
        begin
            if (bv_reg[2] && en)
                skid_res_reg <= res_next;
        end
        else if (skid_valid_reg)
        begin
            out_res_reg <= skid_res_reg;
        end
        else if (en)
        begin
            out_res_reg <= res_next;
        end
    end

    assign res_valid   = out_valid_reg;
    assign hit         = out_res_reg.hit;
    assign distance_t  = out_res_reg.t;
    assign hit_x       = $signed(out_res_reg.p[0]);
    assign hit_y       = $signed(out_res_reg.p[1]);
    assign hit_z       = $signed(out_res_reg.p[2]);
    assign emitted_rgb = out_res_reg.rgb;

    // the skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    // a miss carries the all-ones distance and no radiance
    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit |-> distance_t == '1 && emitted_rgb == '0
                              && hit_x == 0 && hit_y == 0 && hit_z == 0)
        else $error("miss beat with non-default fields");

    // a beat taken from the skid goes out next
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && res_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid beat not moved to the output register");

endmodule

[rtl/rrli_div.sv]
// rrli_div: four restoring dividers in lock step, one quotient bit per stage,
// sharing one divisor; a first stage flags quotients that do not fit
// depends on rrli_pkg
module rrli_div (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             en,
    input  logic                                             in_valid,
    input  logic [rrli_pkg::NDIV-1:0][rrli_pkg::DVD_W-1:0]   dividend,
    input  logic [rrli_pkg::DMAG_W-1:0]                      divisor,
    input  rrli_pkg::side_t                                  side_in,
    output logic                                             out_valid,
    output logic [rrli_pkg::NDIV-1:0][rrli_pkg::Q_W-1:0]     quotient,
    output logic [rrli_pkg::NDIV-1:0]                        overflow,
    output rrli_pkg::side_t                                  side_out
);

    logic [rrli_pkg::Q_W:0]                                  v_reg;
    logic [rrli_pkg::NDIV-1:0][rrli_pkg::DVD_W-1:0]          rem_reg  [rrli_pkg::Q_W+1];
    logic [rrli_pkg::NDIV-1:0][rrli_pkg::Q_W-1:0]            quo_reg  [rrli_pkg::Q_W+1];
    logic [rrli_pkg::DMAG_W-1:0]                             dsr_reg  [rrli_pkg::Q_W+1];
    logic [rrli_pkg::NDIV-1:0]                               ovf_reg  [rrli_pkg::Q_W+1];
    rrli_pkg::side_t                                         side_reg [rrli_pkg::Q_W+1];

    logic [rrli_pkg::NDIV-1:0][rrli_pkg::DVD_W-1:0]          rem_next [rrli_pkg::Q_W];
    logic [rrli_pkg::NDIV-1:0][rrli_pkg::Q_W-1:0]            quo_next [rrli_pkg::Q_W];
    logic [rrli_pkg::NDIV-1:0]                               ovf_next;

    // overflow when the quotient needs more than Q_W bits
    always_comb
    begin
        for (int j = 0; j < rrli_pkg::NDIV; j++)
        begin
            ovf_next[j] = {{(rrli_pkg::CMP_W-rrli_pkg::DVD_W){1'b0}}, dividend[j]}
                          >= {divisor, {rrli_pkg::Q_W{1'b0}}};
        end
    end

    // one trial subtraction per stage, msb first
    always_comb
    begin
        logic [rrli_pkg::CMP_W-1:0] sh;
        logic [rrli_pkg::CMP_W-1:0] rx;
        logic [rrli_pkg::CMP_W-1:0] diff;
        logic                       ge;
        sh   = '0;
        rx   = '0;
        diff = '0;
        ge   = 1'b0;
        for (int k = 0; k < rrli_pkg::Q_W; k++)
        begin
            for (int j = 0; j < rrli_pkg::NDIV; j++)
            begin
                sh   = {{rrli_pkg::Q_W{1'b0}}, dsr_reg[k]} << (rrli_pkg::Q_W - 1 - k);
                rx   = {{(rrli_pkg::CMP_W-rrli_pkg::DVD_W){1'b0}}, rem_reg[k][j]};
                diff = rx - sh;
                ge   = rx >= sh;
                rem_next[k][j] = ge ? diff[rrli_pkg::DVD_W-1:0] : rem_reg[k][j];
                quo_next[k][j] = {quo_reg[k][j][rrli_pkg::Q_W-2:0], ge};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[rrli_pkg::Q_W-1:0], in_valid};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= dividend;
            quo_reg[0]  <= '0;
            dsr_reg[0]  <= divisor;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side_in;
            for (int k = 0; k < rrli_pkg::Q_W; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                quo_reg[k+1]  <= quo_next[k];
                dsr_reg[k+1]  <= dsr_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[rrli_pkg::Q_W];
    assign quotient  = quo_reg[rrli_pkg::Q_W];
    assign overflow  = ovf_reg[rrli_pkg::Q_W];
    assign side_out  = side_reg[rrli_pkg::Q_W];

endmodule
